@@ hdl/sst_pkg.sv @@
// Operation codes for the sparse set row table.
package sst_pkg;
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_LOOKUP    = 3'd0;
    localparam t_kind KIND_EMPLACE   = 3'd1;
    localparam t_kind KIND_WRITE     = 3'd2;
    localparam t_kind KIND_ERASE     = 3'd3;
    localparam t_kind KIND_READ_SLOT = 3'd4;
    localparam t_kind KIND_CLEAR_ROW = 3'd5;
    localparam t_kind KIND_CLEAR_ALL = 3'd6;
endpackage

@@ hdl/sst_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sparse_set_row_table_unit.sv @@
// Sparse set row table: one sparse set of (column, value) entries per row.
// One operation is in flight at a time. Lookup, emplace, write, read slot and
// the unused code pass S_MAP, S_DEN and S_OUT; an erase that hits adds S_ERS.
// Lookup, emplace and write make two dependent reads of registered memories:
// the slot map, then the dense list at the position it returns. Clear row
// sweeps the row's COLS slot-map entries, clear all all ROWS*COLS, one per
// cycle; after reset all ROWS*COLS are swept before the first transfer is
// taken. A new item may enter while the previous result waits.
module sparse_set_row_table_unit #(
    parameter int ROWS        = 16,
    parameter int COLS        = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_kind,
    input  logic [3:0]             i_row_sel,
    input  logic [7:0]             i_column,
    input  logic [7:0]             i_position,
    input  logic [VALUE_WIDTH-1:0] i_value_in,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_present,
    output logic [VALUE_WIDTH-1:0] o_value_out,
    output logic [7:0]             o_column_out,
    output logic [7:0]             o_slot_out,
    output logic [8:0]             o_row_count
);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = $clog2(COLS);
    localparam int NW    = $clog2(COLS + 1);
    localparam int MW    = CW + 1;
    localparam int DW    = CW + VALUE_WIDTH;

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_MAP, S_DEN, S_ERS, S_CLR, S_OUT} t_state;

    t_state r_state;
    sst_pkg::t_kind r_kind;
    logic [3:0] r_row;
    logic [7:0] r_col;
    logic [7:0] r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic r_had;
    logic [CW-1:0] r_slot;
    logic [NW-1:0] r_cnt [ROWS];
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_clr_end;
    logic r_init;
    logic r_res_present;
    logic [VALUE_WIDTH-1:0] r_res_value;
    logic [CW-1:0] r_res_col;
    logic [CW-1:0] r_res_slot;
    logic [NW-1:0] r_res_count;

    logic map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [MW-1:0] map_wdata, map_rdata;
    logic den_we;
    logic [AW-1:0] den_waddr, den_raddr;
    logic [DW-1:0] den_wdata, den_rdata;

    logic [RW-1:0] ri;
    logic row_ok, col_ok, map_had;
    logic [CW-1:0] ci, pi, last, lcol;
    logic [NW-1:0] cnt;
    logic [VALUE_WIDTH-1:0] dval;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(COLS) + AW'(c));
    endfunction

    assign ri      = RW'(r_row);
    assign row_ok  = 32'(r_row) < ROWS;
    assign col_ok  = 32'(r_col) < COLS;
    assign ci      = CW'(r_col);
    assign pi      = CW'(r_pos);
    assign cnt     = r_cnt[ri];
    assign last    = CW'(cnt - NW'(1));
    assign lcol    = den_rdata[DW-1:VALUE_WIDTH];
    assign dval    = den_rdata[VALUE_WIDTH-1:0];
    assign map_had = map_rdata[MW-1] && col_ok && row_ok;
    assign o_ready = r_state == S_IDLE;

    sst_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    sst_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dense (
        .i_clk(i_clk), .i_we(den_we), .i_waddr(den_waddr), .i_wdata(den_wdata),
        .i_raddr(den_raddr), .o_rdata(den_rdata)
    );

    always_comb begin
        map_we    = 1'b0;
        map_waddr = f_addr(ri, ci);
        map_wdata = '0;
        map_raddr = f_addr(RW'(i_row_sel), CW'(i_column));
        den_we    = 1'b0;
        den_waddr = f_addr(ri, r_slot);
        den_wdata = {ci, r_val};
        den_raddr = f_addr(ri, map_rdata[CW-1:0]);
        case (r_state)
            S_MAP: begin
                if (r_kind == sst_pkg::KIND_READ_SLOT) begin
                    den_raddr = f_addr(ri, pi);
                end else if (r_kind == sst_pkg::KIND_ERASE) begin
                    den_raddr = f_addr(ri, last);
                end
            end
            S_DEN: begin
                if (row_ok && col_ok) begin
                    case (r_kind)
                        sst_pkg::KIND_EMPLACE, sst_pkg::KIND_WRITE: begin
                            if (!r_had) begin
                                if (32'(cnt) < COLS) begin
                                    map_we    = 1'b1;
                                    map_wdata = {1'b1, CW'(cnt)};
                                    den_we    = 1'b1;
                                    den_waddr = f_addr(ri, CW'(cnt));
                                end
                            end else if (r_kind == sst_pkg::KIND_WRITE) begin
                                den_we = 1'b1;
                            end
                        end
                        sst_pkg::KIND_ERASE: begin
                            if (r_had && lcol != ci) begin
                                den_we    = 1'b1;
                                den_wdata = den_rdata;
                                map_we    = 1'b1;
                                map_waddr = f_addr(ri, lcol);
                                map_wdata = {1'b1, r_slot};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ERS: begin
                map_we = 1'b1;
            end
            S_INIT, S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_clr_end  <= AW'(CELLS - 1);
            o_valid    <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT, S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == r_clr_end) begin
                        r_state <= r_init ? S_IDLE : S_OUT;
                        r_init  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_row   <= i_row_sel;
                        r_col   <= i_column;
                        r_pos   <= i_position;
                        r_val   <= i_value_in;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_had  <= map_had;
                    r_slot <= map_rdata[CW-1:0];
                    r_res_present <= 1'b0;
                    r_res_value   <= '0;
                    r_res_col     <= '0;
                    r_res_slot    <= '0;
                    if (row_ok && r_kind == sst_pkg::KIND_CLEAR_ROW) begin
                        r_clr_addr  <= f_addr(ri, '0);
                        r_clr_end   <= f_addr(ri, CW'(COLS - 1));
                        r_cnt[ri]   <= '0;
                        r_res_count <= '0;
                        r_state     <= S_CLR;
                    end else if (row_ok && r_kind == sst_pkg::KIND_CLEAR_ALL) begin
                        r_clr_addr <= '0;
                        r_clr_end  <= AW'(CELLS - 1);
                        for (int i = 0; i < ROWS; i++) begin
                            r_cnt[i] <= '0;
                        end
                        r_res_count <= '0;
                        r_state     <= S_CLR;
                    end else begin
                        r_res_count <= row_ok ? cnt : '0;
                        r_state     <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_state <= (row_ok && r_kind == sst_pkg::KIND_ERASE && r_had)
                               ? S_ERS : S_OUT;
                    if (row_ok) begin
                        case (r_kind)
                            sst_pkg::KIND_LOOKUP: begin
                                if (r_had) begin
                                    r_res_present <= 1'b1;
                                    r_res_value   <= dval;
                                    r_res_col     <= ci;
                                    r_res_slot    <= r_slot;
                                end
                            end
                            sst_pkg::KIND_EMPLACE, sst_pkg::KIND_WRITE: begin
                                if (col_ok) begin
                                    if (!r_had) begin
                                        if (32'(cnt) < COLS) begin
                                            r_cnt[ri]   <= cnt + NW'(1);
                                            r_res_count <= cnt + NW'(1);
                                            r_res_value <= r_val;
                                            r_res_col   <= ci;
                                            r_res_slot  <= CW'(cnt);
                                        end
                                    end else begin
                                        r_res_present <= 1'b1;
                                        r_res_value   <= (r_kind == sst_pkg::KIND_WRITE)
                                                         ? r_val : dval;
                                        r_res_col     <= ci;
                                        r_res_slot    <= r_slot;
                                    end
                                end
                            end
                            sst_pkg::KIND_ERASE: begin
                                if (r_had) begin
                                    r_res_present <= 1'b1;
                                    r_cnt[ri]     <= cnt - NW'(1);
                                    r_res_count   <= cnt - NW'(1);
                                end
                            end
                            sst_pkg::KIND_READ_SLOT: begin
                                if (32'(r_pos) < 32'(cnt)) begin
                                    r_res_present <= 1'b1;
                                    r_res_value   <= dval;
                                    r_res_col     <= lcol;
                                    r_res_slot    <= pi;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ERS: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid      <= 1'b1;
                        o_present    <= r_res_present;
                        o_value_out  <= r_res_value;
                        o_column_out <= 8'(r_res_col);
                        o_slot_out   <= 8'(r_res_slot);
                        o_row_count  <= 9'(r_res_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/sst_checker.sv @@
// Checker for the sparse set row table: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module sst_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_row_sel,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_value_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_present,
    input  logic [31:0] i_value_out,
    input  logic [7:0]  i_column_out,
    input  logic [7:0]  i_slot_out,
    input  logic [8:0]  i_row_count,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    typedef struct packed {
        logic        present;
        logic [31:0] value;
        logic [7:0]  column;
        logic [7:0]  slot;
        logic [8:0]  count;
    } t_answer;

    logic        col_used [16][256];
    logic [7:0]  col_slot [16][256];
    logic [7:0]  row_cols [16][256];
    logic [31:0] row_vals [16][256];
    logic [8:0]  row_fill [16];
    t_answer     answers[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
        for (int r = 0; r < 16; r++) begin
            row_fill[r] = '0;
            for (int c = 0; c < 256; c++) col_used[r][c] = 1'b0;
        end
    end

    assign o_pending = answers.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic void wipe_row(input int r);
        for (int p = 0; p < row_fill[r]; p++) col_used[r][row_cols[r][p]] = 1'b0;
        row_fill[r] = '0;
    endfunction

    function automatic t_answer table_step(input sst_pkg::t_kind k, input int r,
                                           input logic [7:0] c,
                                           input logic [7:0] pos, input logic [31:0] v);
        t_answer a;
        logic had;
        int hole, last;
        a = '0;
        had = col_used[r][c];
        case (k)
            sst_pkg::KIND_LOOKUP: if (had) begin
                a.present = 1'b1;
                a.slot    = col_slot[r][c];
                a.value   = row_vals[r][a.slot];
                a.column  = c;
            end
            sst_pkg::KIND_EMPLACE, sst_pkg::KIND_WRITE: begin
                if (!had && row_fill[r] < 256) begin
                    col_slot[r][c] = row_fill[r][7:0];
                    col_used[r][c] = 1'b1;
                    row_cols[r][row_fill[r]] = c;
                    row_vals[r][row_fill[r]] = v;
                    row_fill[r]++;
                end
                if (col_used[r][c]) begin
                    if (k == sst_pkg::KIND_WRITE) row_vals[r][col_slot[r][c]] = v;
                    a.present = had;
                    a.slot    = col_slot[r][c];
                    a.value   = row_vals[r][a.slot];
                    a.column  = c;
                end
            end
            sst_pkg::KIND_ERASE: if (had) begin
                hole = col_slot[r][c];
                last = row_fill[r] - 1;
                if (row_cols[r][last] != c) begin
                    row_cols[r][hole] = row_cols[r][last];
                    row_vals[r][hole] = row_vals[r][last];
                    col_slot[r][row_cols[r][last]] = hole[7:0];
                end
                col_used[r][c] = 1'b0;
                row_fill[r] = last[8:0];
                a.present = 1'b1;
            end
            sst_pkg::KIND_READ_SLOT: if (pos < row_fill[r]) begin
                a.present = 1'b1;
                a.value   = row_vals[r][pos];
                a.column  = row_cols[r][pos];
                a.slot    = pos;
            end
            sst_pkg::KIND_CLEAR_ROW: wipe_row(r);
            sst_pkg::KIND_CLEAR_ALL: for (int i = 0; i < 16; i++) wipe_row(i);
            default: ;
        endcase
        a.count = row_fill[r];
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                answers.push_back(table_step(sst_pkg::t_kind'(i_kind), i_row_sel, i_column,
                                             i_position, i_value_in));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (answers.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = answers.pop_front();
                    if (i_present !== want.present) report("present", i_present, want.present);
                    if (i_value_out !== want.value) report("value", i_value_out, want.value);
                    if (i_column_out !== want.column)
                        report("column", i_column_out, want.column);
                    if (i_slot_out !== want.slot) report("slot", i_slot_out, want.slot);
                    if (i_row_count !== want.count) report("count", i_row_count, want.count);
                end
            end
        end
    end
endmodule

@@ tb/testbench.sv @@
// Testbench top for the sparse set row table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, o_valid, i_ready;
    logic [2:0]  i_kind;
    logic [3:0]  i_row_sel;
    logic [7:0]  i_column, i_position;
    logic [31:0] i_value_in;
    logic        o_present;
    logic [31:0] o_value_out;
    logic [7:0]  o_column_out, o_slot_out;
    logic [8:0]  o_row_count;
    int          errors, pending, results, items, idle_cycles;
    logic        hold_off;

    sparse_set_row_table_unit dut (.*);

    sst_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_kind(i_kind), .i_row_sel(i_row_sel), .i_column(i_column),
        .i_position(i_position), .i_value_in(i_value_in), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_present(o_present), .i_value_out(o_value_out),
        .i_column_out(o_column_out), .i_slot_out(o_slot_out), .i_row_count(o_row_count),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    task automatic send(input sst_pkg::t_kind k, input int r, input int c, input int p,
                        input logic [31:0] v);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind     <= k;
        i_row_sel  <= r[3:0];
        i_column   <= c[7:0];
        i_position <= p[7:0];
        i_value_in <= v;
        i_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items++;
        @(negedge i_clk);
    endtask

    task automatic random_item(input int hot_row);
        int pick, r, c;
        pick = $urandom_range(0, 99);
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : hot_row;
        c = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        if (pick < 25) send(sst_pkg::KIND_EMPLACE, r, c, $urandom, $urandom);
        else if (pick < 45) send(sst_pkg::KIND_WRITE, r, c, $urandom, $urandom);
        else if (pick < 65) send(sst_pkg::KIND_LOOKUP, r, c, $urandom, $urandom);
        else if (pick < 82) send(sst_pkg::KIND_ERASE, r, c, $urandom, $urandom);
        else if (pick < 96)
            send(sst_pkg::KIND_READ_SLOT, r, c, $urandom_range(0, 20), $urandom);
        else if (pick < 98) send(sst_pkg::KIND_CLEAR_ROW, r, c, $urandom, $urandom);
        else if (pick < 99) send(sst_pkg::KIND_CLEAR_ALL, r, c, $urandom, $urandom);
        else send(sst_pkg::t_kind'(3'd7), r, c, $urandom, $urandom);
    endtask

    initial begin
        i_ready <= 1'b0;
        hold_off = 1'b0;
        @(negedge i_clk);
        while (1) begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat (gap_length() + 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (1) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        items      = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_kind     = sst_pkg::KIND_LOOKUP;
        i_row_sel  = '0;
        i_column   = '0;
        i_position = '0;
        i_value_in = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(sst_pkg::KIND_LOOKUP, 0, 0, 0, 0);
        send(sst_pkg::KIND_EMPLACE, 0, 0, 0, 32'hFFFF_FFFF);
        send(sst_pkg::KIND_EMPLACE, 0, 0, 0, 32'h1234_5678);
        send(sst_pkg::KIND_WRITE, 0, 255, 0, 32'h0000_0000);
        send(sst_pkg::KIND_WRITE, 0, 255, 0, 32'hAAAA_5555);
        send(sst_pkg::KIND_EMPLACE, 15, 255, 0, 32'h5555_AAAA);
        send(sst_pkg::KIND_EMPLACE, 15, 128, 0, 32'h8000_0001);
        send(sst_pkg::KIND_LOOKUP, 15, 255, 0, 0);
        send(sst_pkg::KIND_READ_SLOT, 0, 0, 1, 0);
        send(sst_pkg::KIND_READ_SLOT, 0, 0, 2, 0);
        send(sst_pkg::KIND_READ_SLOT, 0, 0, 255, 0);
        send(sst_pkg::KIND_ERASE, 0, 0, 0, 0);
        send(sst_pkg::KIND_ERASE, 0, 0, 0, 0);
        send(sst_pkg::KIND_LOOKUP, 0, 255, 0, 0);
        send(sst_pkg::KIND_ERASE, 0, 255, 0, 0);
        send(sst_pkg::t_kind'(3'd7), 15, 7, 0, 32'hFFFF_FFFF);
        send(sst_pkg::KIND_CLEAR_ROW, 15, 0, 0, 0);
        send(sst_pkg::KIND_LOOKUP, 15, 128, 0, 0);
        send(sst_pkg::KIND_EMPLACE, 3, 9, 0, 32'h0F0F_0F0F);
        send(sst_pkg::KIND_CLEAR_ALL, 0, 0, 0, 0);
        send(sst_pkg::KIND_READ_SLOT, 3, 0, 0, 0);

        for (int c = 0; c < 256; c++) send(sst_pkg::KIND_EMPLACE, 7, c, 0, $urandom);
        send(sst_pkg::KIND_READ_SLOT, 7, 0, 255, 0);
        hold_off = 1'b1;
        for (int k = 0; k < 20; k++)
            send(sst_pkg::KIND_ERASE, 7, $urandom_range(0, 255), 0, 0);
        send(sst_pkg::KIND_CLEAR_ROW, 7, 0, 0, 0);

        while (items < 1050) random_item($urandom_range(0, 15));
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d operations, checked %0d results, including a full row,", items, results);
        $display("erase with move-down, clears, unused code and a long receiver stall.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
